// ===== hdl/byte_pair_to_seven_segment_digits_macros.svh =====
// Assertion macros shared by the byte pair to seven-segment digit block.
`ifndef BYTE_PAIR_TO_SEVEN_SEGMENT_DIGITS_MACROS_SVH
`define BYTE_PAIR_TO_SEVEN_SEGMENT_DIGITS_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BPSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bpsd_pkg.sv =====
// Types, constants and digit tables for the byte pair to seven-segment digit block.
package bpsd_pkg;

	localparam int NUM_DIGITS = 5;
	localparam int IDX_W      = 3;
	localparam int VAL_W      = 16;
	localparam int THR_W      = 17;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
	} bpsd_num_t;

	function automatic logic [THR_W-1:0] power_of_ten(input logic [IDX_W-1:0] idx);
		logic [THR_W-1:0] p;
		unique case (idx)
			3'd0:    p = 17'd10000;
			3'd1:    p = 17'd1000;
			3'd2:    p = 17'd100;
			3'd3:    p = 17'd10;
			default: p = 17'd1;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0:    s = 8'h3f;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5b;
			4'd3:    s = 8'h4f;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6d;
			4'd6:    s = 8'h7d;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7f;
			default: s = 8'h6f;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/bpsd_pair.sv =====
// Byte pairing: holds the high byte and registers the assembled 16-bit number.
module bpsd_pair (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	output bpsd_pkg::bpsd_num_t num_s1,
	input  logic                num_take
);
	import bpsd_pkg::*;

	logic       phase_q;
	logic [7:0] high_q;
	logic       valid_s1;
	logic [VAL_W-1:0] value_s1;
	logic       accept;

	assign in_stall = valid_s1 && !num_take;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			high_q   <= 8'h00;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (!phase_q) begin
					high_q  <= rx_byte;
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
				end
			end
			if (accept && phase_q) begin
				valid_s1 <= 1'b1;
			end else if (num_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q) begin
			value_s1 <= {high_q, rx_byte};
		end
	end

	assign num_s1.valid = valid_s1;
	assign num_s1.value = value_s1;

endmodule

// ===== hdl/bpsd_scan.sv =====
// Digit scan: extracts one decimal digit per step and drives the result register.
`include "byte_pair_to_seven_segment_digits_macros.svh"

module bpsd_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  bpsd_pkg::bpsd_num_t num_s1,
	output logic                num_take,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          segment_pattern,
	output logic [7:0]          select_pattern,
	output logic                last_digit
);
	import bpsd_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [VAL_W-1:0] rem_q;
	logic             out_valid_q;
	logic [7:0]       seg_q;
	logic [7:0]       sel_q;
	logic             last_q;

	logic             out_free;
	logic             step;
	logic [THR_W-1:0] pw;
	logic [THR_W-1:0] thr_sel;
	logic [3:0]       digit;
	logic [VAL_W-1:0] rem_next;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = busy_q && out_free;
	assign num_take = num_s1.valid && (!busy_q || (step && idx_q == LAST_IDX));

	// digit = how many multiples of the current power fit in the remainder
	always_comb begin
		pw      = power_of_ten(idx_q);
		digit   = 4'd0;
		thr_sel = '0;
		for (int j = 1; j <= 9; j++) begin
			if ({1'b0, rem_q} >= THR_W'(pw * THR_W'(j))) begin
				digit   = 4'(j);
				thr_sel = THR_W'(pw * THR_W'(j));
			end
		end
		rem_next = VAL_W'({1'b0, rem_q} - thr_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= busy_q;
			end
			if (num_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (step) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			seg_q  <= seg_of(digit);
			sel_q  <= ~(8'd1 << idx_q);
			last_q <= (idx_q == LAST_IDX);
		end
		if (num_take) begin
			rem_q <= num_s1.value;
		end else if (step) begin
			rem_q <= rem_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign segment_pattern = seg_q;
	assign select_pattern  = sel_q;
	assign last_digit      = last_q;

	`BPSD_ASSERT_IMP(a_last_sel, clk, arst_n, out_valid_q && last_q, sel_q == 8'hef, "last word not on fifth digit")
	`BPSD_ASSERT_IMP(a_sel_hot, clk, arst_n, out_valid_q, $onehot(~sel_q), "digit select not one-hot")
	`BPSD_ASSERT_NXT(a_step_out, clk, arst_n, step, out_valid_q, "digit step lost its word")
	`BPSD_ASSERT_IMP(a_idx_rng, clk, arst_n, busy_q, idx_q <= LAST_IDX, "digit index past last digit")

endmodule

// ===== hdl/byte_pair_to_seven_segment_digits.sv =====
// Top level: byte pairs in, five seven-segment digit words out per pair.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | rx_byte
//  out     | out_valid / out_stall| segment_pattern, select_pattern, last_digit
//
// A high byte word is taken and gives no output word.
// A low byte word is registered, then its five digit words leave one per cycle
// while out_stall is low; the next number is taken with the last digit. The
// rate is set by the single digit-extraction step shared by all five digits.
// Reset clears the pairing phase, so a half-received pair is dropped.
// out_stall holds the current word; in_stall rises only while a number waits.
module byte_pair_to_seven_segment_digits (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segment_pattern,
	output logic [7:0] select_pattern,
	output logic       last_digit
);
	import bpsd_pkg::*;

	bpsd_num_t num_s1;
	logic      num_take;

	bpsd_pair u_pair (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.num_s1   (num_s1),
		.num_take (num_take)
	);

	bpsd_scan u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.num_s1          (num_s1),
		.num_take        (num_take),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.segment_pattern (segment_pattern),
		.select_pattern  (select_pattern),
		.last_digit      (last_digit)
	);

endmodule
